### sv/session_table_packet_classifier_defines.svh
// ----------------------------------------------------------------------------
// Session table packet classifier assertion macros
// Shared property forms for the checker of the session table.
// ----------------------------------------------------------------------------
`ifndef SESSION_TABLE_PACKET_CLASSIFIER_DEFINES_SVH
`define SESSION_TABLE_PACKET_CLASSIFIER_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define STPC_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define STPC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

### sv/stpc_pkg.sv
// ----------------------------------------------------------------------------
// Session table packet classifier package
// Opcodes, cause codes, filter constants and the token passed between cells.
// ----------------------------------------------------------------------------
package stpc_pkg;

	// Request opcodes
	localparam logic [1:0] OP_ESTABLISH = 2'd0;
	localparam logic [1:0] OP_RELEASE   = 2'd1;
	localparam logic [1:0] OP_CLASSIFY  = 2'd2;

	// Result causes
	localparam logic [1:0] CAUSE_NONE      = 2'd0;
	localparam logic [1:0] CAUSE_INVALID   = 2'd1;
	localparam logic [1:0] CAUSE_NOT_FOUND = 2'd2;
	localparam logic [1:0] CAUSE_FULL      = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_HOP_ADDR   = 2'd0;
	localparam logic [1:0] REG_MEDIA_LOW  = 2'd1;
	localparam logic [1:0] REG_MEDIA_HIGH = 2'd2;

	// Configuration reset values
	localparam logic [31:0] HOP_ADDR_RESET   = 32'hAC10_0001;
	localparam logic [15:0] MEDIA_LOW_RESET  = 16'd16384;
	localparam logic [15:0] MEDIA_HIGH_RESET = 16'd32767;

	// Filter constants
	localparam logic [7:0]  PROTO_UDP    = 8'd17;
	localparam logic [15:0] PORT_HTTPS   = 16'd443;
	localparam logic [15:0] PORT_RTMP    = 16'd1935;
	localparam logic [7:0]  QOS_MEDIA    = 8'd1;
	localparam logic [7:0]  QOS_STREAM   = 8'd4;
	localparam logic [7:0]  NET_PRIV_A   = 8'd10;
	localparam logic [15:0] NET_PRIV_C   = 16'hC0A8;

	// Operation a token performs as it walks the cell chain
	typedef enum logic [2:0] {
		CELL_NOP   = 3'd0,
		CELL_EST   = 3'd1,
		CELL_REL   = 3'd2,
		CELL_UNMAP = 3'd3,
		CELL_CLS   = 3'd4
	} cell_op_t;

	// Token handed from cell to cell
	typedef struct packed {
		logic        vld;
		cell_op_t    op;
		logic [31:0] key;
		logic [31:0] num;
		logic [7:0]  qos;
		logic        hit;
	} tok_t;

	// One result item
	typedef struct packed {
		logic        success;
		logic [1:0]  cause;
		logic [31:0] new_session;
		logic        action;
		logic [31:0] fwd_hop;
		logic [7:0]  match_qos;
	} res_t;

endpackage

### sv/session_table_packet_classifier.sv
// ----------------------------------------------------------------------------
// Session table packet classifier
// Session table of SESSIONS entries held in a chain of cells; serves
// establish, release and classify requests one at a time.
// ----------------------------------------------------------------------------
// A request walks the chain of SESSIONS cells, one cell per cycle, and its
// result is then registered. A new request is taken only once the last one
// has left the chain and the holding register is empty. A release that
// finds its session walks the chain twice (first to find the entry and its
// UE address, then to unmap that address everywhere). A
// finished result waits in the output register or a one-entry holding
// register, so the next request can be taken before the result is consumed.
// Configuration writes land at once and are meant for idle periods.
module session_table_packet_classifier #(
	parameter int SESSIONS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic        subscriber_present,
	input  logic        ue_present,
	input  logic [31:0] ue_address,
	input  logic [7:0]  sess_qos,
	input  logic [31:0] session_number,
	input  logic [31:0] src_address,
	input  logic [31:0] dst_address,
	input  logic [7:0]  protocol,
	input  logic [15:0] dest_port,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        success,
	output logic [1:0]  cause,
	output logic [31:0] new_session,
	output logic        action,
	output logic [31:0] fwd_hop,
	output logic [7:0]  match_qos
);

	localparam int CntW = $clog2(SESSIONS + 1);

	logic [31:0]    hop_addr_q;
	logic [15:0]    media_low_q;
	logic [15:0]    media_high_q;
	logic [CntW-1:0] count_q;
	logic [31:0]    next_session_q;
	logic           busy_q;
	logic [1:0]     req_cause_q;
	logic [31:0]    req_assigned_q;
	logic [31:0]    req_dst_q;
	logic [7:0]     req_proto_q;
	logic [15:0]    req_port_q;
	logic           inj_vld_q;
	stpc_pkg::tok_t inj_q;
	stpc_pkg::tok_t inj_nxt;
	stpc_pkg::tok_t link [SESSIONS+1];
	stpc_pkg::tok_t tail;
	stpc_pkg::res_t res;
	stpc_pkg::res_t out_q;
	stpc_pkg::res_t pend_q;
	logic           out_vld_q;
	logic           pend_vld_q;
	logic           accept;
	logic           est_ok;
	logic           full;
	logic           reinject;
	logic           done;
	logic           take;
	logic           in_media;
	logic           private_dst;
	logic           fwd;
	logic [1:0]     cause_nxt;

	assign in_ready = !busy_q && !pend_vld_q;
	assign accept   = in_valid && in_ready;
	assign full     = (count_q == CntW'(SESSIONS));
	assign est_ok   = (opcode == stpc_pkg::OP_ESTABLISH) && subscriber_present
	                  && ue_present && !full;

	// Build the token for a new request, or the unmap token of a release that found its session
	always_comb begin
		inj_nxt     = '0;
		inj_nxt.op  = stpc_pkg::CELL_NOP;
		cause_nxt   = stpc_pkg::CAUSE_NONE;
		unique case (opcode)
			stpc_pkg::OP_ESTABLISH: begin
				if (!subscriber_present || !ue_present) begin
					cause_nxt = stpc_pkg::CAUSE_INVALID;
				end else if (full) begin
					cause_nxt = stpc_pkg::CAUSE_FULL;
				end else begin
					inj_nxt.op  = stpc_pkg::CELL_EST;
					inj_nxt.key = ue_address;
					inj_nxt.num = next_session_q;
					inj_nxt.qos = sess_qos;
				end
			end
			stpc_pkg::OP_RELEASE: begin
				inj_nxt.op  = stpc_pkg::CELL_REL;
				inj_nxt.num = session_number;
			end
			stpc_pkg::OP_CLASSIFY: begin
				inj_nxt.op  = stpc_pkg::CELL_CLS;
				inj_nxt.key = src_address;
			end
			default: begin
			end
		endcase
		if (reinject) begin
			inj_nxt     = '0;
			inj_nxt.op  = stpc_pkg::CELL_UNMAP;
			inj_nxt.key = tail.key;
		end
	end

	// Chain of cells
	always_comb begin
		link[0]     = inj_q;
		link[0].vld = inj_vld_q;
	end

	for (genvar g = 0; g < SESSIONS; g++) begin : g_cell
		stpc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (link[g]),
			.tok_out (link[g+1])
		);
	end

	assign tail     = link[SESSIONS];
	assign reinject = tail.vld && (tail.op == stpc_pkg::CELL_REL) && tail.hit;
	assign done     = tail.vld && !reinject;
	assign take     = out_vld_q && out_ready;

	// Classify filters
	assign in_media    = (req_port_q >= media_low_q) && (req_port_q <= media_high_q);
	assign private_dst = (req_dst_q[31:24] == stpc_pkg::NET_PRIV_A)
	                     || (req_dst_q[31:16] == stpc_pkg::NET_PRIV_C);

	always_comb begin
		if (private_dst) begin
			fwd = 1'b0;
		end else if (tail.qos == stpc_pkg::QOS_MEDIA) begin
			fwd = (req_proto_q == stpc_pkg::PROTO_UDP) && in_media;
		end else if (tail.qos == stpc_pkg::QOS_STREAM) begin
			fwd = (req_port_q == stpc_pkg::PORT_HTTPS)
			      || (req_port_q == stpc_pkg::PORT_RTMP) || in_media;
		end else begin
			fwd = 1'b1;
		end
	end

	// Form the result when the token leaves the chain
	always_comb begin
		res = '0;
		unique case (tail.op)
			stpc_pkg::CELL_NOP: begin
				res.cause = req_cause_q;
			end
			stpc_pkg::CELL_EST: begin
				res.success     = 1'b1;
				res.new_session = req_assigned_q;
			end
			stpc_pkg::CELL_REL: begin
				res.cause = stpc_pkg::CAUSE_NOT_FOUND;
			end
			stpc_pkg::CELL_UNMAP: begin
				res.success = 1'b1;
			end
			stpc_pkg::CELL_CLS: begin
				if (tail.hit) begin
					res.match_qos = tail.qos;
					res.action    = fwd;
					res.fwd_hop   = fwd ? hop_addr_q : 32'd0;
				end
			end
			default: begin
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hop_addr_q     <= stpc_pkg::HOP_ADDR_RESET;
			media_low_q    <= stpc_pkg::MEDIA_LOW_RESET;
			media_high_q   <= stpc_pkg::MEDIA_HIGH_RESET;
			count_q        <= '0;
			next_session_q <= '0;
			busy_q         <= 1'b0;
			inj_vld_q      <= 1'b0;
			out_vld_q      <= 1'b0;
			pend_vld_q     <= 1'b0;
		end else begin
			// Write configuration
			if (cfg_write) begin
				unique case (cfg_index)
					stpc_pkg::REG_HOP_ADDR:   hop_addr_q   <= cfg_data;
					stpc_pkg::REG_MEDIA_LOW:  media_low_q  <= cfg_data[15:0];
					stpc_pkg::REG_MEDIA_HIGH: media_high_q <= cfg_data[15:0];
					default: begin
					end
				endcase
			end

			// Track occupancy and session numbering
			if (accept && est_ok) begin
				count_q        <= count_q + CntW'(1);
				next_session_q <= next_session_q + 32'd1;
			end else if (reinject) begin
				count_q <= count_q - CntW'(1);
			end

			inj_vld_q <= accept || reinject;

			if (accept) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end

			// Hold results in the output or holding register
			if (done) begin
				if (!out_vld_q || take) begin
					out_vld_q <= 1'b1;
				end else begin
					pend_vld_q <= 1'b1;
				end
			end else if (take) begin
				if (pend_vld_q) begin
					pend_vld_q <= 1'b0;
				end else begin
					out_vld_q <= 1'b0;
				end
			end
		end
	end

	// Request payload and result data
	always_ff @(posedge clk) begin
		if (accept || reinject) begin
			inj_q <= inj_nxt;
		end
		if (accept) begin
			req_cause_q    <= cause_nxt;
			req_assigned_q <= next_session_q;
			req_dst_q      <= dst_address;
			req_proto_q    <= protocol;
			req_port_q     <= dest_port;
		end
		if (done) begin
			if (!out_vld_q || take) begin
				out_q <= res;
			end else begin
				pend_q <= res;
			end
		end else if (take && pend_vld_q) begin
			out_q <= pend_q;
		end
	end

	assign out_valid   = out_vld_q;
	assign success     = out_q.success;
	assign cause       = out_q.cause;
	assign new_session = out_q.new_session;
	assign action      = out_q.action;
	assign fwd_hop     = out_q.fwd_hop;
	assign match_qos   = out_q.match_qos;

endmodule

### sv/stpc_cell.sv
// ----------------------------------------------------------------------------
// Session table cell
// Holds one session entry, applies the passing token to it and forwards the
// token to the next cell in the next cycle.
// ----------------------------------------------------------------------------
module stpc_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  stpc_pkg::tok_t  tok_in,
	output stpc_pkg::tok_t  tok_out
);

	logic           valid_q;
	logic           mapped_q;
	logic [31:0]    session_q;
	logic [31:0]    ue_q;
	logic [7:0]     qos_q;
	logic           tok_vld_q;
	stpc_pkg::tok_t tok_q;
	stpc_pkg::tok_t tok_nxt;
	logic           key_hit;
	logic           num_hit;
	logic           claim;
	logic           release_hit;
	logic           unmap_hit;

	// Compare the entry against the token
	assign key_hit = valid_q && mapped_q && (ue_q == tok_in.key);
	assign num_hit = valid_q && (session_q == tok_in.num);

	assign claim       = tok_in.vld && (tok_in.op == stpc_pkg::CELL_EST)
	                     && !valid_q && !tok_in.hit;
	assign release_hit = tok_in.vld && (tok_in.op == stpc_pkg::CELL_REL)
	                     && num_hit && !tok_in.hit;
	assign unmap_hit   = tok_in.vld && key_hit
	                     && ((tok_in.op == stpc_pkg::CELL_EST)
	                      || (tok_in.op == stpc_pkg::CELL_UNMAP));

	// Mark the first match and pick up what later stages need
	always_comb begin
		tok_nxt = tok_in;
		unique case (tok_in.op)
			stpc_pkg::CELL_EST: begin
				if (!valid_q && !tok_in.hit) tok_nxt.hit = 1'b1;
			end
			stpc_pkg::CELL_REL: begin
				if (num_hit && !tok_in.hit) begin
					tok_nxt.hit = 1'b1;
					tok_nxt.key = ue_q;
				end
			end
			stpc_pkg::CELL_CLS: begin
				if (key_hit && !tok_in.hit) begin
					tok_nxt.hit = 1'b1;
					tok_nxt.qos = qos_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Update entry flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			mapped_q  <= 1'b0;
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_in.vld;
			if (claim) begin
				valid_q  <= 1'b1;
				mapped_q <= 1'b1;
			end else if (release_hit) begin
				valid_q  <= 1'b0;
				mapped_q <= 1'b0;
			end else if (unmap_hit) begin
				mapped_q <= 1'b0;
			end
		end
	end

	// Write entry payload on claim, advance the token
	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
		if (claim) begin
			session_q <= tok_in.num;
			ue_q      <= tok_in.key;
			qos_q     <= tok_in.qos;
		end
	end

	always_comb begin
		tok_out     = tok_q;
		tok_out.vld = tok_vld_q;
	end

endmodule

### sv/stpc_checker.sv
// ----------------------------------------------------------------------------
// Session table packet classifier checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "session_table_packet_classifier_defines.svh"

module stpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        success,
	input logic [1:0]  cause,
	input logic [31:0] new_session,
	input logic        action,
	input logic [31:0] fwd_hop
);

	// Hold a stalled result
	`STPC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`STPC_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(new_session) && $stable(cause) && $stable(fwd_hop), "result changed while stalled")

	// Forwarded packets carry no request status
	`STPC_ASSERT_NOW(a_fwd_clean, clk, arst_n, out_valid && action, !success && (cause == stpc_pkg::CAUSE_NONE) && (new_session == 32'd0), "forward with request status")

	// Drops and non-classify results carry no next hop
	`STPC_ASSERT_NOW(a_drop_hop, clk, arst_n, out_valid && !action, fwd_hop == 32'd0, "next hop without forward")

	// Failed requests assign nothing
	`STPC_ASSERT_NOW(a_fail_clean, clk, arst_n, out_valid && (cause != stpc_pkg::CAUSE_NONE), !success && (new_session == 32'd0), "failure with success fields")

endmodule

bind session_table_packet_classifier stpc_checker u_stpc_checker (.*);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session table packet classifier testbench
// Sends establish, release and classify requests with random gaps on both
// handshakes, keeps its own copy of the session table to predict each result,
// and checks every result field as it leaves the block.
// ----------------------------------------------------------------------------
module testbench;

	localparam int TABLE_SIZE      = 16;
	localparam int CLK_PERIOD      = 4;
	localparam int RESET_CYCLES    = 11;
	localparam int DRAIN_CYCLES    = 2 * TABLE_SIZE + 4;
	localparam int QUIET_LIMIT     = 4000;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 115;
	localparam int POOL_SIZE       = 8;

	localparam logic [1:0]  OP_UNUSED  = 2'd3;
	localparam logic [31:0] PUBLIC_DST = 32'h0808_0808;
	localparam logic [7:0]  PROTO_TCP  = 8'd6;

	typedef struct {
		logic [1:0]  op;
		logic        sub_ok;
		logic        ue_ok;
		logic [31:0] ue;
		logic [7:0]  qos;
		logic [31:0] num;
		logic [31:0] src;
		logic [31:0] dst;
		logic [7:0]  proto;
		logic [15:0] port;
	} request_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = stpc_pkg::REG_HOP_ADDR;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  opcode = stpc_pkg::OP_ESTABLISH;
	logic        subscriber_present = 1'b0;
	logic        ue_present = 1'b0;
	logic [31:0] ue_address = '0;
	logic [7:0]  sess_qos = '0;
	logic [31:0] session_number = '0;
	logic [31:0] src_address = '0;
	logic [31:0] dst_address = '0;
	logic [7:0]  protocol = '0;
	logic [15:0] dest_port = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        success;
	logic [1:0]  cause;
	logic [31:0] new_session;
	logic        action;
	logic [31:0] fwd_hop;
	logic [7:0]  match_qos;

	// Predicted session table and register copies
	logic        tbl_valid   [TABLE_SIZE] = '{default: 1'b0};
	logic        tbl_mapped  [TABLE_SIZE] = '{default: 1'b0};
	logic [31:0] tbl_session [TABLE_SIZE] = '{default: '0};
	logic [31:0] tbl_ue      [TABLE_SIZE] = '{default: '0};
	logic [7:0]  tbl_qos     [TABLE_SIZE] = '{default: '0};
	logic [31:0] session_counter = '0;
	logic [31:0] hop_cfg = stpc_pkg::HOP_ADDR_RESET;
	logic [15:0] port_lo_cfg = stpc_pkg::MEDIA_LOW_RESET;
	logic [15:0] port_hi_cfg = stpc_pkg::MEDIA_HIGH_RESET;

	request_t        pending_requests [$];
	stpc_pkg::res_t  expected_results [$];
	request_t        held_req;
	logic [31:0]     ue_pool [POOL_SIZE];

	int items_queued = 0;
	int results_checked = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int send_gap = 0;
	int recv_gap = 0;
	logic send_idle_on = 1'b1;
	logic recv_idle_on = 1'b1;

	session_table_packet_classifier #(
		.SESSIONS(TABLE_SIZE)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.subscriber_present(subscriber_present),
		.ue_present(ue_present),
		.ue_address(ue_address),
		.sess_qos(sess_qos),
		.session_number(session_number),
		.src_address(src_address),
		.dst_address(dst_address),
		.protocol(protocol),
		.dest_port(dest_port),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.success(success),
		.cause(cause),
		.new_session(new_session),
		.action(action),
		.fwd_hop(fwd_hop),
		.match_qos(match_qos)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Gap length: mostly none or short, now and then long
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic port_in_media(input logic [15:0] port);
		return port >= port_lo_cfg && port <= port_hi_cfg;
	endfunction

	// Drop the mapping of an address from every live entry
	function automatic void unmap_ue(input logic [31:0] addr);
		for (int i = 0; i < TABLE_SIZE; i++)
			if (tbl_valid[i] && tbl_mapped[i] && tbl_ue[i] == addr)
				tbl_mapped[i] = 1'b0;
	endfunction

	// Apply one request to the predicted table and return its result
	function automatic stpc_pkg::res_t serve_request(input request_t r);
		stpc_pkg::res_t res;
		int slot;
		logic pass;
		res = '0;
		slot = -1;
		case (r.op)
			stpc_pkg::OP_ESTABLISH: begin
				if (!r.sub_ok || !r.ue_ok) begin
					res.cause = stpc_pkg::CAUSE_INVALID;
				end else begin
					for (int i = TABLE_SIZE - 1; i >= 0; i--)
						if (!tbl_valid[i])
							slot = i;
					if (slot < 0) begin
						res.cause = stpc_pkg::CAUSE_FULL;
					end else begin
						res.new_session = session_counter;
						session_counter = session_counter + 32'd1;
						unmap_ue(r.ue);
						tbl_valid[slot] = 1'b1;
						tbl_mapped[slot] = 1'b1;
						tbl_session[slot] = res.new_session;
						tbl_ue[slot] = r.ue;
						tbl_qos[slot] = r.qos;
						res.success = 1'b1;
					end
				end
			end
			stpc_pkg::OP_RELEASE: begin
				for (int i = TABLE_SIZE - 1; i >= 0; i--)
					if (tbl_valid[i] && tbl_session[i] == r.num)
						slot = i;
				if (slot < 0) begin
					res.cause = stpc_pkg::CAUSE_NOT_FOUND;
				end else begin
					unmap_ue(tbl_ue[slot]);
					tbl_valid[slot] = 1'b0;
					tbl_mapped[slot] = 1'b0;
					res.success = 1'b1;
				end
			end
			stpc_pkg::OP_CLASSIFY: begin
				for (int i = TABLE_SIZE - 1; i >= 0; i--)
					if (tbl_valid[i] && tbl_mapped[i] && tbl_ue[i] == r.src)
						slot = i;
				if (slot >= 0) begin
					res.match_qos = tbl_qos[slot];
					if (r.dst[31:24] == stpc_pkg::NET_PRIV_A
						|| r.dst[31:16] == stpc_pkg::NET_PRIV_C)
						pass = 1'b0;
					else if (res.match_qos == stpc_pkg::QOS_MEDIA)
						pass = r.proto == stpc_pkg::PROTO_UDP && port_in_media(r.port);
					else if (res.match_qos == stpc_pkg::QOS_STREAM)
						pass = r.port == stpc_pkg::PORT_HTTPS || r.port == stpc_pkg::PORT_RTMP
							|| port_in_media(r.port);
					else
						pass = 1'b1;
					if (pass) begin
						res.action = 1'b1;
						res.fwd_hop = hop_cfg;
					end
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// Fill every field with noise so unused fields toggle too
	function automatic request_t noise_request(input logic [1:0] op);
		request_t r;
		r.op = op;
		r.sub_ok = 1'($urandom_range(0, 1));
		r.ue_ok = 1'($urandom_range(0, 1));
		r.ue = $urandom;
		r.qos = 8'($urandom);
		r.num = $urandom;
		r.src = $urandom;
		r.dst = $urandom;
		r.proto = 8'($urandom);
		r.port = 16'($urandom);
		return r;
	endfunction

	function automatic request_t establish_req(input logic sub_ok, input logic ue_ok,
		input logic [31:0] ue, input logic [7:0] qos);
		request_t r;
		r = noise_request(stpc_pkg::OP_ESTABLISH);
		r.sub_ok = sub_ok;
		r.ue_ok = ue_ok;
		r.ue = ue;
		r.qos = qos;
		return r;
	endfunction

	function automatic request_t release_req(input logic [31:0] num);
		request_t r;
		r = noise_request(stpc_pkg::OP_RELEASE);
		r.num = num;
		return r;
	endfunction

	function automatic request_t classify_req(input logic [31:0] src, input logic [31:0] dst,
		input logic [7:0] proto, input logic [15:0] port);
		request_t r;
		r = noise_request(stpc_pkg::OP_CLASSIFY);
		r.src = src;
		r.dst = dst;
		r.proto = proto;
		r.port = port;
		return r;
	endfunction

	// Build a mostly well-formed request from the current table contents
	function automatic request_t random_request(input int est_pct, input int rel_pct);
		request_t r;
		int live [$];
		int pick;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] port;
		logic [7:0] qos;
		for (int i = 0; i < TABLE_SIZE; i++)
			if (tbl_valid[i])
				live.push_back(i);
		pick = $urandom_range(0, 99);
		if (pick < est_pct) begin
			case ($urandom_range(0, 4))
				0: qos = 8'd0;
				1: qos = stpc_pkg::QOS_MEDIA;
				2: qos = stpc_pkg::QOS_STREAM;
				3: qos = 8'hFF;
				default: qos = 8'($urandom);
			endcase
			r = establish_req($urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
				$urandom_range(0, 99) < 85 ? ue_pool[$urandom_range(0, POOL_SIZE - 1)]
					: 32'($urandom), qos);
		end else if (pick < est_pct + rel_pct) begin
			pick = $urandom_range(0, 9);
			if (live.size() > 0 && pick < 8)
				r = release_req(tbl_session[live[$urandom_range(0, live.size() - 1)]]);
			else if (pick < 9)
				r = release_req(session_counter - 32'($urandom_range(0, 40)));
			else
				r = release_req($urandom);
		end else if (pick < 95) begin
			pick = $urandom_range(0, 9);
			if (live.size() > 0 && pick < 7)
				src = tbl_ue[live[$urandom_range(0, live.size() - 1)]];
			else if (pick < 9)
				src = ue_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				src = $urandom;
			dst = $urandom;
			case ($urandom_range(0, 9))
				0: dst[31:24] = stpc_pkg::NET_PRIV_A;
				1: dst[31:16] = stpc_pkg::NET_PRIV_C;
				2: dst[31:24] = stpc_pkg::NET_PRIV_A + 8'd1;
				3: dst[31:16] = stpc_pkg::NET_PRIV_C + 16'd1;
				default: begin
				end
			endcase
			case ($urandom_range(0, 9))
				0: port = stpc_pkg::PORT_HTTPS;
				1: port = stpc_pkg::PORT_RTMP;
				2: port = port_lo_cfg;
				3: port = port_hi_cfg;
				4: port = port_lo_cfg - 16'd1;
				5: port = port_hi_cfg + 16'd1;
				6, 7: port = 16'($urandom_range(port_lo_cfg, port_hi_cfg));
				default: port = 16'($urandom);
			endcase
			r = classify_req(src, dst,
				$urandom_range(0, 1) ? stpc_pkg::PROTO_UDP : 8'($urandom), port);
		end else begin
			r = noise_request(OP_UNUSED);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d field %s got 0x%0h want 0x%0h",
				results_checked, name, got, want));
	endtask

	// Check one result against the oldest prediction
	task automatic check_result();
		stpc_pkg::res_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("result with no request pending");
			return;
		end
		want = expected_results.pop_front();
		compare_field("success", 32'(success), 32'(want.success));
		compare_field("cause", 32'(cause), 32'(want.cause));
		compare_field("new_session", new_session, want.new_session);
		compare_field("action", 32'(action), 32'(want.action));
		compare_field("fwd_hop", fwd_hop, want.fwd_hop);
		compare_field("match_qos", 32'(match_qos), 32'(want.match_qos));
		results_checked++;
	endtask

	// Hand a request to the driver, keeping only a short backlog
	task automatic queue_request(input request_t r);
		while (pending_requests.size() >= 2)
			@(posedge clk);
		pending_requests.push_back(r);
		items_queued++;
	endtask

	task automatic wait_results();
		while (results_checked != items_queued)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			stpc_pkg::REG_HOP_ADDR:   hop_cfg = value;
			stpc_pkg::REG_MEDIA_LOW:  port_lo_cfg = value[15:0];
			stpc_pkg::REG_MEDIA_HIGH: port_hi_cfg = value[15:0];
			default: begin
			end
		endcase
	endtask

	// Present queued requests and predict each accepted one
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(serve_request(held_req));
				send_gap = send_idle_on ? idle_gap() : 0;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					held_req = pending_requests.pop_front();
					opcode <= held_req.op;
					subscriber_present <= held_req.sub_ok;
					ue_present <= held_req.ue_ok;
					ue_address <= held_req.ue;
					sess_qos <= held_req.qos;
					session_number <= held_req.num;
					src_address <= held_req.src;
					dst_address <= held_req.dst;
					protocol <= held_req.proto;
					dest_port <= held_req.port;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Take results and stall the output side at random
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				check_result();
				recv_gap = recv_idle_on ? idle_gap() : 0;
			end else if (recv_idle_on && recv_gap == 0 && $urandom_range(0, 15) == 0) begin
				recv_gap = idle_gap();
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// End the run when no request moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[%0t] no progress for %0d cycles", $realtime, QUIET_LIMIT);
				$display("testbench failed");
				$finish;
			end
		end
	end

	initial begin
		int est_pct;
		int rel_pct;
		logic [15:0] port_base;
		ue_pool[0] = 32'h0000_0000;
		ue_pool[1] = 32'hFFFF_FFFF;
		ue_pool[2] = 32'h0A01_0203;
		ue_pool[3] = 32'hC0A8_0101;
		for (int i = 4; i < POOL_SIZE; i++)
			ue_pool[i] = $urandom;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests under the reset register values
		queue_request(classify_req(ue_pool[4], PUBLIC_DST, stpc_pkg::PROTO_UDP,
			stpc_pkg::MEDIA_LOW_RESET));
		queue_request(release_req(32'd0));
		queue_request(establish_req(1'b0, 1'b1, ue_pool[4], stpc_pkg::QOS_MEDIA));
		queue_request(establish_req(1'b1, 1'b0, ue_pool[4], stpc_pkg::QOS_MEDIA));
		queue_request(establish_req(1'b0, 1'b0, ue_pool[4], stpc_pkg::QOS_MEDIA));
		queue_request(noise_request(OP_UNUSED));
		queue_request(establish_req(1'b1, 1'b1, ue_pool[4], stpc_pkg::QOS_MEDIA));
		queue_request(classify_req(ue_pool[4], PUBLIC_DST, stpc_pkg::PROTO_UDP,
			stpc_pkg::MEDIA_LOW_RESET));
		queue_request(classify_req(ue_pool[4], PUBLIC_DST, stpc_pkg::PROTO_UDP,
			stpc_pkg::MEDIA_HIGH_RESET));
		queue_request(classify_req(ue_pool[4], PUBLIC_DST, stpc_pkg::PROTO_UDP,
			stpc_pkg::MEDIA_LOW_RESET - 16'd1));
		queue_request(classify_req(ue_pool[4], PUBLIC_DST, PROTO_TCP,
			stpc_pkg::MEDIA_LOW_RESET));
		queue_request(classify_req(ue_pool[4], 32'h0A00_0001, stpc_pkg::PROTO_UDP,
			stpc_pkg::MEDIA_LOW_RESET));
		queue_request(classify_req(ue_pool[4], 32'hC0A8_FFFF, stpc_pkg::PROTO_UDP,
			stpc_pkg::MEDIA_LOW_RESET));
		queue_request(classify_req(ue_pool[4], 32'hC0A9_0000, stpc_pkg::PROTO_UDP,
			stpc_pkg::MEDIA_LOW_RESET));
		queue_request(establish_req(1'b1, 1'b1, ue_pool[5], stpc_pkg::QOS_STREAM));
		queue_request(classify_req(ue_pool[5], PUBLIC_DST, PROTO_TCP, stpc_pkg::PORT_HTTPS));
		queue_request(classify_req(ue_pool[5], PUBLIC_DST, PROTO_TCP, stpc_pkg::PORT_RTMP));
		queue_request(classify_req(ue_pool[5], PUBLIC_DST, PROTO_TCP, 16'h0000));
		queue_request(classify_req(ue_pool[5], PUBLIC_DST, PROTO_TCP, 16'hFFFF));
		// Remap the first address to a newer session, then release the older one
		queue_request(establish_req(1'b1, 1'b1, ue_pool[4], 8'hFF));
		queue_request(classify_req(ue_pool[4], PUBLIC_DST, PROTO_TCP, 16'h0000));
		queue_request(release_req(32'd0));
		queue_request(classify_req(ue_pool[4], PUBLIC_DST, PROTO_TCP, 16'h0000));
		queue_request(establish_req(1'b1, 1'b1, 32'hFFFF_FFFF, 8'd0));
		queue_request(classify_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF));
		wait_results();

		// Random phases, each under its own register setting and idling pattern
		for (int p = 0; p < PHASES; p++) begin
			port_base = 16'($urandom_range(0, 30000));
			case (p)
				0: begin
					write_register(stpc_pkg::REG_HOP_ADDR, 32'h0000_0000);
					write_register(stpc_pkg::REG_MEDIA_LOW, 32'h0000_0000);
					write_register(stpc_pkg::REG_MEDIA_HIGH, 32'h0000_FFFF);
					est_pct = 60;
					rel_pct = 10;
				end
				1: begin
					write_register(stpc_pkg::REG_HOP_ADDR, 32'hFFFF_FFFF);
					write_register(stpc_pkg::REG_MEDIA_LOW, 32'h0000_FFFF);
					write_register(stpc_pkg::REG_MEDIA_HIGH, 32'h0000_0000);
					est_pct = 30;
					rel_pct = 25;
				end
				2: begin
					write_register(stpc_pkg::REG_HOP_ADDR, $urandom);
					write_register(stpc_pkg::REG_MEDIA_LOW, {16'd0, port_base});
					write_register(stpc_pkg::REG_MEDIA_HIGH, {16'd0, port_base});
					est_pct = 25;
					rel_pct = 35;
				end
				3: begin
					write_register(stpc_pkg::REG_HOP_ADDR, stpc_pkg::HOP_ADDR_RESET);
					write_register(stpc_pkg::REG_MEDIA_LOW, {16'd0, stpc_pkg::MEDIA_LOW_RESET});
					write_register(stpc_pkg::REG_MEDIA_HIGH,
						{16'd0, stpc_pkg::MEDIA_HIGH_RESET});
					est_pct = 40;
					rel_pct = 20;
				end
				4: begin
					write_register(stpc_pkg::REG_HOP_ADDR, $urandom);
					write_register(stpc_pkg::REG_MEDIA_LOW, {16'd0, port_base});
					write_register(stpc_pkg::REG_MEDIA_HIGH,
						{16'd0, port_base + 16'($urandom_range(0, 30000))});
					est_pct = 35;
					rel_pct = 25;
				end
				default: begin
					write_register(stpc_pkg::REG_HOP_ADDR, $urandom);
					write_register(stpc_pkg::REG_MEDIA_LOW, {16'd0, stpc_pkg::PORT_HTTPS});
					write_register(stpc_pkg::REG_MEDIA_HIGH, 32'h0000_FFFF);
					est_pct = 15;
					rel_pct = 50;
				end
			endcase
			send_idle_on = p != 1 && p != 3;
			recv_idle_on = p != 2 && p != 3;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Now and then hold the sender until the table has caught up
				if ($urandom_range(0, 79) == 0)
					wait_results();
				queue_request(random_request(est_pct, rel_pct));
			end
			wait_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
